[rtl/fdss_pkg.sv]
package fdss_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int SLOT_W     = $clog2(NUM_DIGITS);
   localparam int LEN_W      = $clog2(NUM_DIGITS + 1);
   localparam int VALUE_W    = 32;
   localparam int CODE_W     = 4;
   localparam int SEG_W      = 7;
   localparam int DWELL_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // magnitudes that fit four digits are below 10000, so 14 bits hold them
   localparam int MAG_W   = 14;
   localparam int HUND_W  = 7;
   localparam int TEN_W   = 4;
   localparam logic [VALUE_W-1:0] VALUE_LIMIT = 32'd10000;

   // floor(x / 100) = (x * 10486) >> 20 for x < 10000
   localparam logic [MAG_W-1:0] DIV100_MUL   = 14'd10486;
   localparam int               DIV100_SHIFT = 20;
   localparam logic [MAG_W-1:0] HUNDRED      = 14'd100;

   // floor(x / 10) = (x * 205) >> 11 for x < 100
   localparam int               DIV10_W     = 15;
   localparam logic [7:0]       DIV10_MUL   = 8'd205;
   localparam int               DIV10_SHIFT = 11;
   localparam logic [HUND_W-1:0] TEN        = 7'd10;

   localparam logic [MAG_W-1:0] THOUSAND_MAG = 14'd1000;
   localparam logic [MAG_W-1:0] HUNDRED_MAG  = 14'd100;
   localparam logic [MAG_W-1:0] TEN_MAG      = 14'd10;

   localparam logic [CODE_W-1:0]  MINUS_CODE  = 4'd10;
   localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1000;

   localparam logic [CSR_ADDR_W-3:0] REG_DWELL_TICKS = 1'b0;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef struct packed {
      func_type                          func;
      logic                              neg;
      logic                              too_big;
      logic [LEN_W-1:0]                  num_digits;
      logic [NUM_DIGITS-1:0][CODE_W-1:0] digits;
   } load_type;

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
      logic [SEG_W-1:0] pattern;
      unique case (code)
         4'd0:       pattern = 7'h40;
         4'd1:       pattern = 7'h79;
         4'd2:       pattern = 7'h24;
         4'd3:       pattern = 7'h30;
         4'd4:       pattern = 7'h19;
         4'd5:       pattern = 7'h12;
         4'd6:       pattern = 7'h02;
         4'd7:       pattern = 7'h78;
         4'd8:       pattern = 7'h00;
         4'd9:       pattern = 7'h10;
         MINUS_CODE: pattern = 7'h3F;
         default:    pattern = 7'h7F;
      endcase
      return pattern;
   endfunction

   // splits a value below 100 into its tens and ones digits
   function automatic logic [2*CODE_W-1:0] split_tens(input logic [HUND_W-1:0] x);
      logic [DIV10_W-1:0] prod;
      logic [TEN_W-1:0]   tens;
      logic [HUND_W-1:0]  tens_x10;
      logic [HUND_W-1:0]  ones;
      prod     = DIV10_W'(x) * DIV10_W'(DIV10_MUL);
      tens     = prod[DIV10_SHIFT +: TEN_W];
      tens_x10 = HUND_W'(tens) * TEN;
      ones     = x - tens_x10;
      return {tens, ones[CODE_W-1:0]};
   endfunction

endpackage

[rtl/fdss_csr.sv]
module fdss_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fdss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fdss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fdss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [fdss_pkg::DWELL_W-1:0]      dwell_ticks
);
   import fdss_pkg::*;

   logic [DWELL_W-1:0] dwell_ff;
   logic [DWELL_W-1:0] dwell_in;
   logic               sel_dwell;

   assign pready    = 1'b1;
   assign sel_dwell = (paddr[CSR_ADDR_W-1:2] == REG_DWELL_TICKS);

   always_comb begin
      dwell_in = dwell_ff;
      if (psel && penable && pwrite && pready && sel_dwell) begin
         dwell_in = pwdata[DWELL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff <= DWELL_RESET;
      end else begin
         dwell_ff <= dwell_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_dwell) begin
         prdata = CSR_DATA_W'(dwell_ff);
      end
   end

   assign dwell_ticks = dwell_ff;

endmodule

[rtl/fdss_digit_split.sv]
module fdss_digit_split (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            in_func,
   input  logic [fdss_pkg::VALUE_W-1:0]    in_value,
   output logic                            out_valid,
   input  logic                            out_ready,
   output fdss_pkg::load_type              out_load
);
   import fdss_pkg::*;

   // stage a: input register
   logic               a_valid_ff, a_valid_in;
   logic               a_func_ff;
   logic [VALUE_W-1:0] a_value_ff;

   // stage b: magnitude split at the hundreds
   logic               b_valid_ff, b_valid_in;
   logic               b_func_ff;
   logic               b_neg_ff;
   logic               b_too_big_ff;
   logic [LEN_W-1:0]   b_len_ff;
   logic [MAG_W-1:0]   b_mag_ff;
   logic [HUND_W-1:0]  b_hi_ff;

   logic                a_ready, b_ready;
   logic                a_neg, a_too_big;
   logic [VALUE_W-1:0]  a_mag;
   logic [MAG_W-1:0]    a_mag14;
   logic [LEN_W-1:0]    a_len;
   logic [2*MAG_W-1:0]  a_prod;
   logic [HUND_W-1:0]   a_hi;

   logic [MAG_W-1:0]    b_hund;
   logic [MAG_W-1:0]    b_lo_full;
   logic [2*CODE_W-1:0] b_hi_split, b_lo_split;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_ready) begin
         a_valid_in = in_valid;
      end
      b_valid_in = b_valid_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
      end
   end

   always_comb begin
      a_neg     = a_value_ff[VALUE_W-1];
      a_mag     = a_neg ? (VALUE_W'(0) - a_value_ff) : a_value_ff;
      a_too_big = (a_mag >= VALUE_LIMIT);
      a_mag14   = a_mag[MAG_W-1:0];
      if (a_mag14 >= THOUSAND_MAG) begin
         a_len = LEN_W'(4);
      end else if (a_mag14 >= HUNDRED_MAG) begin
         a_len = LEN_W'(3);
      end else if (a_mag14 >= TEN_MAG) begin
         a_len = LEN_W'(2);
      end else begin
         a_len = LEN_W'(1);
      end
      a_prod = (2*MAG_W)'(a_mag14) * (2*MAG_W)'(DIV100_MUL);
      a_hi   = a_prod[DIV100_SHIFT +: HUND_W];
   end

   always_comb begin
      b_hund     = MAG_W'(b_hi_ff) * HUNDRED;
      b_lo_full  = b_mag_ff - b_hund;
      b_hi_split = split_tens(b_hi_ff);
      b_lo_split = split_tens(b_lo_full[HUND_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_func_ff  <= in_func;
         a_value_ff <= in_value;
      end
      if (b_ready) begin
         b_func_ff    <= a_func_ff;
         b_neg_ff     <= a_neg;
         b_too_big_ff <= a_too_big;
         b_len_ff     <= a_len;
         b_mag_ff     <= a_mag14;
         b_hi_ff      <= a_hi;
      end
   end

   always_comb begin
      out_valid           = b_valid_ff;
      out_load.func       = func_type'(b_func_ff);
      out_load.neg        = b_neg_ff;
      out_load.too_big    = b_too_big_ff;
      out_load.num_digits = b_len_ff;
      out_load.digits[0]  = b_hi_split[2*CODE_W-1:CODE_W];
      out_load.digits[1]  = b_hi_split[CODE_W-1:0];
      out_load.digits[2]  = b_lo_split[2*CODE_W-1:CODE_W];
      out_load.digits[3]  = b_lo_split[CODE_W-1:0];
   end

endmodule

[rtl/fdss_display.sv]
module fdss_display (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fdss_pkg::DWELL_W-1:0]    dwell_ticks,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  fdss_pkg::load_type              in_load,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fdss_pkg::SLOT_W-1:0]     rsp_active_digit,
   output logic [fdss_pkg::CODE_W-1:0]     rsp_symbol,
   output logic [fdss_pkg::SEG_W-1:0]      rsp_segments_low,
   output logic                            rsp_status
);
   import fdss_pkg::*;

   logic [CODE_W-1:0]  store_ff [NUM_DIGITS];
   logic [CODE_W-1:0]  store_in [NUM_DIGITS];
   logic [SLOT_W-1:0]  pos_ff, pos_in;
   logic [DWELL_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_digit_ff, rsp_digit_in;
   logic [CODE_W-1:0]  rsp_symbol_ff, rsp_symbol_in;
   logic [SEG_W-1:0]   rsp_seg_ff, rsp_seg_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               transfer;
   logic [CODE_W-1:0]  loaded [NUM_DIGITS];
   logic [CODE_W-1:0]  shifted [NUM_DIGITS];
   logic [LEN_W-1:0]   src_idx [NUM_DIGITS];
   logic               full_width;
   logic [DWELL_W:0]   count_next;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign transfer = in_valid && in_ready;
   assign full_width = (in_load.num_digits == LEN_W'(NUM_DIGITS));

   // left-aligned digits, then the minus shift for short negatives
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         src_idx[i] = LEN_W'(i) + LEN_W'(NUM_DIGITS) - in_load.num_digits;
         loaded[i]  = store_ff[i];
         if (LEN_W'(i) < in_load.num_digits) begin
            loaded[i] = in_load.digits[src_idx[i][SLOT_W-1:0]];
         end
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
         shifted[i] = loaded[i];
      end
      if (in_load.neg && !full_width) begin
         shifted[0] = MINUS_CODE;
         for (int i = 1; i < NUM_DIGITS; i++) begin
            shifted[i] = loaded[i-1];
         end
      end
   end

   always_comb begin
      store_in      = store_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      rsp_status_in = 1'b0;
      count_next    = (DWELL_W+1)'(count_ff) + (DWELL_W+1)'(1);
      if (transfer) begin
         if (in_load.func == FUNC_LOAD) begin
            if (in_load.too_big) begin
               rsp_status_in = 1'b1;
            end else begin
               store_in      = shifted;
               rsp_status_in = in_load.neg && full_width;
            end
         end else begin
            if (count_next >= (DWELL_W+1)'(dwell_ticks)) begin
               count_in = '0;
               pos_in   = pos_ff + SLOT_W'(1);
            end else begin
               count_in = count_next[DWELL_W-1:0];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_digit_in  = rsp_digit_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_seg_in    = rsp_seg_ff;
      if (transfer) begin
         rsp_valid_in  = 1'b1;
         rsp_digit_in  = pos_in;
         rsp_symbol_in = store_in[pos_in];
         rsp_seg_in    = seg_pattern(store_in[pos_in]);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            store_ff[i] <= '0;
         end
         pos_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         store_ff      <= store_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_digit_ff  <= rsp_digit_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_seg_ff    <= rsp_seg_in;
      if (transfer) begin
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_active_digit = rsp_digit_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_segments_low = rsp_seg_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

[rtl/four_digit_seven_segment_scanner_top.sv]
// four-digit seven-segment scanner
// req channel: req_func selects a load (0) of req_value or one time tick (1)
// rsp channel: one result per request with the lit slot, its symbol code,
//   the active-low segment pattern and an overflow status bit
// a load splits the value into decimal digits and writes the four-slot store;
//   values over four digits flag status and leave the store alone
// ticks advance the dwell counter; the scan steps to the next slot after
//   dwell_ticks ticks (a dwell of zero acts as one)
// csr port: dwell_ticks at byte address 0, reset value 1000, pready tied high
// a request passes the input register, the hundreds split register and the
//   result register before rsp_valid rises and the result can transfer
// throughput: one request per cycle unless stalled; the store and scan state
//   sit in one register stage, so each item sees the state left by the one before
// reset clears the store, scan position, dwell count and all valid flags
// when rsp_ready is low the result is held and the pipeline fills, then
//   req_ready drops until the result transfer frees a stage
module four_digit_seven_segment_scanner_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic signed [31:0]              req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_active_digit,
   output logic [3:0]                      rsp_symbol,
   output logic [6:0]                      rsp_segments_low,
   output logic                            rsp_status,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fdss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fdss_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fdss_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import fdss_pkg::*;

   logic [DWELL_W-1:0] dwell_ticks;
   logic               split_valid;
   logic               split_ready;
   load_type           split_load;

   fdss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .dwell_ticks (dwell_ticks)
   );

   fdss_digit_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_func   (req_func),
      .in_value  (VALUE_W'(req_value)),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_load  (split_load)
   );

   fdss_display u_display (
      .clock            (clock),
      .reset            (reset),
      .dwell_ticks      (dwell_ticks),
      .in_valid         (split_valid),
      .in_ready         (split_ready),
      .in_load          (split_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_active_digit (rsp_active_digit),
      .rsp_symbol       (rsp_symbol),
      .rsp_segments_low (rsp_segments_low),
      .rsp_status       (rsp_status)
   );

endmodule
